FILE: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int MAX_RESULTS         = 8;
   localparam int COUNT_W             = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W               = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } jsu_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_byte_valid;
      logic       string_end;
      logic       run_last;
   } jsu_rsp_type;

   // all results caused by one input item
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [IDX_W-1:0]            last_idx;
      logic                        data_valid;
      logic                        ended;
   } jsu_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jsu_q_status_type;

endpackage

FILE: design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw string bytes, tracks the escape state and builds the list of
// decoded bytes for each item.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  jsu_pkg::jsu_req_type  req_data,
   output logic                  req_stall,
   input  jsu_pkg::jsu_q_status_type q_status,
   output logic                  push,
   output jsu_pkg::jsu_rec_type  push_rec
);
   import jsu_pkg::*;

   localparam logic [2:0] PH_NORM = 3'd0;
   localparam logic [2:0] PH_ESC  = 3'd1;
   localparam logic [2:0] PH_HEX  = 3'd2;
   localparam logic [2:0] PH_LSL  = 3'd3;
   localparam logic [2:0] PH_LU   = 3'd4;
   localparam logic [2:0] PH_LHEX = 3'd5;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [COUNT_W-1:0]          count;
      logic [2:0]                  phase;
      logic                        ended;
      logic                        closed;
      logic [9:0]                  high;
   } act_type;

   function automatic act_type put(act_type a, logic [7:0] b);
      act_type r;
      r = a;
      if (r.count < COUNT_W'(MAX_RESULTS)) begin
         r.bytes[r.count[IDX_W-1:0]] = b;
         r.count = r.count + 1'b1;
      end
      return r;
   endfunction

   function automatic act_type put_cp(act_type a, logic [20:0] cp);
      act_type r;
      r = a;
      if (cp < 21'h80) begin
         r = put(r, cp[7:0]);
      end else if (cp < 21'h800) begin
         r = put(r, {3'b110, cp[10:6]});
         r = put(r, {2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         r = put(r, {4'hE, cp[15:12]});
         r = put(r, {2'b10, cp[11:6]});
         r = put(r, {2'b10, cp[5:0]});
      end else begin
         r = put(r, {5'b11110, cp[20:18]});
         r = put(r, {2'b10, cp[17:12]});
         r = put(r, {2'b10, cp[11:6]});
         r = put(r, {2'b10, cp[5:0]});
      end
      return r;
   endfunction

   // echo 'u' and the digits gathered so far, in their typed case
   function automatic act_type flush(act_type a, logic [11:0] acc, logic [2:0] cnt,
                                     logic [2:0] up);
      act_type    r;
      logic [1:0] n;
      logic [1:0] pos;
      logic [3:0] v;
      r   = put(a, CH_U);
      n   = (cnt > 3'd3) ? 2'd3 : cnt[1:0];
      pos = 2'd0;
      v   = 4'd0;
      for (int i = 0; i < 3; i++) begin
         if (i < int'(n)) begin
            pos = 2'(int'(n) - 1 - i);
            v   = acc[pos*4 +: 4];
            if (v < 4'd10)        r = put(r, 8'h30 + {4'h0, v});
            else if (up[2'(i)])   r = put(r, 8'h37 + {4'h0, v});
            else                  r = put(r, 8'h57 + {4'h0, v});
         end
      end
      return r;
   endfunction

   function automatic act_type drop_high(act_type a);
      return put_cp(a, {5'b0, 6'b110110, a.high});
   endfunction

   function automatic act_type normal(act_type a, logic [7:0] b, logic last);
      act_type r;
      r = a;
      r.phase = PH_NORM;
      if (b == CH_QUOTE) begin
         r.ended  = 1'b1;
         r.closed = 1'b1;
      end else if (b == CH_BSL) begin
         if (last) r = put(r, CH_BSL);
         else      r.phase = PH_ESC;
      end else begin
         r = put(r, b);
      end
      return r;
   endfunction

   function automatic act_type escape(act_type a, logic [7:0] b, logic last);
      act_type r;
      r = a;
      r.phase = PH_NORM;
      if (b == CH_B)      r = put(r, 8'h08);
      else if (b == CH_F) r = put(r, 8'h0C);
      else if (b == CH_N) r = put(r, 8'h0A);
      else if (b == CH_R) r = put(r, 8'h0D);
      else if (b == CH_T) r = put(r, 8'h09);
      else if (b == CH_U) begin
         if (last) r = put(r, CH_U);
         else      r.phase = PH_HEX;
      end else begin
         r = put(r, b);
      end
      return r;
   endfunction

   // a high surrogate waits for its partner unless the text ends here
   function automatic act_type finish(act_type a, logic [15:0] cp, logic last);
      act_type r;
      r = a;
      r.phase = PH_NORM;
      if (cp[15:10] == 6'b110110 && !last) begin
         r.high  = cp[9:0];
         r.phase = PH_LSL;
      end else begin
         r = put_cp(r, {5'b0, cp});
      end
      return r;
   endfunction

   logic [2:0]  phase_ff, phase_in;
   logic        closed_ff, closed_in;
   logic [11:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [2:0]  upper_ff, upper_in;
   logic [9:0]  high_ff, high_in;

   logic [7:0]  b;
   logic        last;
   logic        accept;
   logic        hex_hit;
   logic [3:0]  hex_val;
   logic        hex_upper_case;
   logic [11:0] acc_take;
   logic [2:0]  cnt_take;
   logic [2:0]  upper_take;
   logic [15:0] word;
   act_type     act;

   assign b         = req_data.in_byte;
   assign last      = req_data.in_last;
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      hex_hit        = 1'b0;
      hex_val        = b[3:0];
      hex_upper_case = (b >= 8'h41) && (b <= 8'h46);
      if (b >= 8'h30 && b <= 8'h39) begin
         hex_hit = 1'b1;
      end else if ((b >= 8'h61 && b <= 8'h66) || hex_upper_case) begin
         hex_hit = 1'b1;
         hex_val = b[3:0] + 4'd9;
      end
   end

   assign acc_take   = {acc_ff[7:0], hex_val};
   assign cnt_take   = cnt_ff + 3'd1;
   assign upper_take = upper_ff |
                       ((hex_upper_case && cnt_ff < 3'd3) ? (3'b001 << cnt_ff) : 3'b000);
   assign word       = {acc_ff, hex_val};

   always_comb begin
      act        = '0;
      act.phase  = phase_ff;
      act.closed = closed_ff;
      act.high   = high_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      upper_in   = upper_ff;
      if (closed_ff) begin
         if (last) begin
            act.closed = 1'b0;
            act.phase  = PH_NORM;
         end
      end else begin
         unique case (phase_ff)
            PH_ESC: act = escape(act, b, last);
            PH_HEX: begin
               if (!hex_hit) begin
                  act = normal(flush(act, acc_ff, cnt_ff, upper_ff), b, last);
               end else if (cnt_ff == 3'd3) begin
                  act = finish(act, word, last);
               end else begin
                  acc_in   = acc_take;
                  cnt_in   = cnt_take;
                  upper_in = upper_take;
                  if (last) begin
                     act       = flush(act, acc_take, cnt_take, upper_take);
                     act.phase = PH_NORM;
                  end
               end
            end
            PH_LSL: begin
               if (b == CH_BSL && !last) act.phase = PH_LU;
               else                      act = normal(drop_high(act), b, last);
            end
            PH_LU: begin
               if (b == CH_U && !last) act.phase = PH_LHEX;
               else                    act = escape(drop_high(act), b, last);
            end
            PH_LHEX: begin
               if (!hex_hit) begin
                  act = normal(flush(drop_high(act), acc_ff, cnt_ff, upper_ff), b, last);
               end else if (cnt_ff == 3'd3) begin
                  if (word[15:10] == 6'b110111) begin
                     act       = put_cp(act, 21'h10000 + {1'b0, high_ff, word[9:0]});
                     act.phase = PH_NORM;
                  end else begin
                     act = finish(drop_high(act), word, last);
                  end
               end else begin
                  acc_in   = acc_take;
                  cnt_in   = cnt_take;
                  upper_in = upper_take;
                  if (last) begin
                     act       = flush(drop_high(act), acc_take, cnt_take, upper_take);
                     act.phase = PH_NORM;
                  end
               end
            end
            default: act = normal(act, b, last);
         endcase
         if (last) begin
            act.ended  = 1'b1;
            act.phase  = PH_NORM;
            act.closed = 1'b0;
         end
      end
      // a fresh run of digits starts from nothing
      if ((act.phase == PH_HEX && phase_ff != PH_HEX) ||
          (act.phase == PH_LHEX && phase_ff != PH_LHEX)) begin
         acc_in   = '0;
         cnt_in   = '0;
         upper_in = '0;
      end
      phase_in  = act.phase;
      closed_in = act.closed;
      high_in   = act.high;
   end

   assign push = accept && !closed_ff && (act.count != '0 || act.ended);

   always_comb begin
      push_rec.bytes      = act.bytes;
      push_rec.data_valid = (act.count != '0);
      push_rec.ended      = act.ended;
      push_rec.last_idx   = (act.count == '0) ? '0 : IDX_W'(act.count - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NORM;
         closed_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         closed_ff <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         upper_ff <= upper_in;
         high_ff  <= high_in;
      end
   end

endmodule

FILE: design/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short queue of per-item result records between front and back.
// ----------------------------------------------------------------------------
module jsu_queue #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  jsu_pkg::jsu_rec_type      push_rec,
   input  logic                      pop,
   output jsu_pkg::jsu_rec_type      head,
   output jsu_pkg::jsu_q_status_type status
);
   import jsu_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   jsu_rec_type      entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_rec;
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

FILE: design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Walks the head record byte by byte into the result output register.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic                      clock,
   input  logic                      reset,
   input  jsu_pkg::jsu_q_status_type q_status,
   input  jsu_pkg::jsu_rec_type      head,
   output logic                      pop,
   output logic                      rsp_valid,
   output jsu_pkg::jsu_rsp_type      rsp_data,
   input  logic                      rsp_stall
);
   import jsu_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   jsu_rsp_type      rsp_data_ff, rsp_data_in;
   logic             out_free;
   logic             take;
   logic             at_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = out_free && !q_status.empty;
   assign at_last  = (idx_ff == head.last_idx);
   assign pop      = take && at_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) rsp_valid_in = !q_status.empty;
      if (take) idx_in = at_last ? '0 : idx_ff + 1'b1;
      rsp_data_in.out_byte       = head.bytes[idx_ff];
      rsp_data_in.out_byte_valid = head.data_valid;
      rsp_data_in.string_end     = head.ended && at_last;
      rsp_data_in.run_last       = at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// JSON string body unescaper with UTF-8 output for \u code points.
// ----------------------------------------------------------------------------
// Takes one raw byte of a JSON string body per cycle and returns the unescaped
// bytes, one result per cycle, while neither req_stall nor rsp_stall is high.
// The front end decodes a whole input item in the cycle it is accepted and
// queues its results (up to eight) as one record; an input item is accepted
// whenever the record queue (QUEUE_DEPTH entries) has room, so bytes that
// decode to one result stream at one item per cycle while rsp_stall is low. A
// multi-result item holds the output until all are out. Results go via the
// record queue and the output register. Items after a closing quote give no
// results, and the in_last item that follows gives none either and reopens
// the block; otherwise every in_last item or closing quote marks string_end.
module json_string_unescape_utf8_core #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  jsu_pkg::jsu_req_type req_data,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output jsu_pkg::jsu_rsp_type rsp_data,
   input  logic                 rsp_stall
);
   import jsu_pkg::*;

   logic             push;
   logic             pop;
   jsu_rec_type      push_rec;
   jsu_rec_type      head;
   jsu_q_status_type q_status;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_status  (q_status),
      .push      (push),
      .push_rec  (push_rec)
   );

   jsu_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // a result with no data byte only closes a string
   a_empty_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_byte_valid |-> rsp_data.string_end && rsp_data.out_byte == 8'h00)
      else $error("data-less result that does not end the string");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_end |-> rsp_data.run_last)
      else $error("string end before last result of item");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("record pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("record popped from empty queue");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
